// ===== hdl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and tables of the differential PSK symbol detector.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

	localparam int HISTORY_BITS_DEF = 32;
	localparam int CORDIC_STEPS     = 15;
	localparam int ITER_W           = $clog2(CORDIC_STEPS);
	localparam int PADDR_W          = 5;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_QPSK_MODE   = 3'd0;
	localparam logic [2:0] REG_REVERSE     = 3'd1;
	localparam logic [2:0] REG_SQL_LEVEL   = 3'd2;
	localparam logic [2:0] REG_SQL_ENABLE  = 3'd3;
	localparam logic [2:0] REG_AFC_ENABLE  = 3'd4;
	localparam logic [2:0] REG_AFC_GAIN    = 3'd5;

	localparam logic [6:0]  SQL_LEVEL_RST = 7'd20;
	localparam logic [15:0] AFC_GAIN_RST  = 16'd2000;

	typedef struct packed {
		logic        qpsk_mode;
		logic        reverse_sideband;
		logic [6:0]  squelch_level;
		logic        squelch_enable;
		logic        afc_enable;
		logic [15:0] afc_gain;
	} psd_cfg_t;

	typedef enum logic [3:0] {
		MUL_PI_SI    = 4'd0,
		MUL_PQ_SQ    = 4'd1,
		MUL_PI_SQ    = 4'd2,
		MUL_PQ_SI    = 4'd3,
		MUL_K_C      = 4'd4,
		MUL_K_S      = 4'd5,
		MUL_G_QR     = 4'd6,
		MUL_G_QI     = 4'd7,
		MUL_QR_QR    = 4'd8,
		MUL_QI_QI    = 4'd9,
		MUL_ERR_GAIN = 4'd10
	} psd_mul_t;

	typedef struct packed {
		psd_mul_t            mul_sel;
		logic                acc_en;
		logic                acc_clr;
		logic                acc_rnd;
		logic                acc_neg;
		logic                cap_in;
		logic                save_re;
		logic                vec_init;
		logic                vec_step;
		logic                decide;
		logic                rot_step;
		logic                qr_load;
		logic                qi_load;
		logic                finish;
		logic                load_out;
		logic [ITER_W-1:0]   iter;
	} psd_cmd_t;

	typedef struct packed {
		logic [15:0]        phase_turn;
		logic [1:0]         decided_bits;
		logic               data_valid;
		logic               carrier_detect;
		logic [6:0]         quality_metric;
		logic signed [15:0] freq_step;
	} psd_res_t;

	// Arctangent of 2^-i as a 16-bit fraction of a turn.
	function automatic logic [15:0] psd_atan(input logic [ITER_W-1:0] i);
		logic [15:0] r;
		case (i)
			4'd0:  r = 16'd8192;
			4'd1:  r = 16'd4836;
			4'd2:  r = 16'd2555;
			4'd3:  r = 16'd1297;
			4'd4:  r = 16'd651;
			4'd5:  r = 16'd326;
			4'd6:  r = 16'd163;
			4'd7:  r = 16'd81;
			4'd8:  r = 16'd41;
			4'd9:  r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			4'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/psd_if.sv =====
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if
// Valid/ready channels for symbols in and detector results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sym_i;
	logic signed [15:0] sym_q;
	modport source(output valid, sym_i, sym_q, input ready);
	modport sink(input valid, sym_i, sym_q, output ready);
endinterface

interface psd_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        phase_turn;
	logic [1:0]         decided_bits;
	logic               data_valid;
	logic               carrier_detect;
	logic [6:0]         quality_metric;
	logic signed [15:0] freq_step;
	modport source(output valid, phase_turn, decided_bits, data_valid, carrier_detect,
		quality_metric, freq_step, input ready);
	modport sink(input valid, phase_turn, decided_bits, data_valid, carrier_detect,
		quality_metric, freq_step, output ready);
endinterface

`default_nettype wire

// ===== hdl/psd_ctrl.sv =====
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer that steps the datapath through one symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output psd_pkg::psd_cmd_t  cmd
);
	import psd_pkg::*;

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_RE0   = 17'h00002,
		ST_RE1   = 17'h00004,
		ST_IM0   = 17'h00008,
		ST_IM1   = 17'h00010,
		ST_VINIT = 17'h00020,
		ST_VEC   = 17'h00040,
		ST_DEC   = 17'h00080,
		ST_ROT   = 17'h00100,
		ST_QR0   = 17'h00200,
		ST_QR1   = 17'h00400,
		ST_QI0   = 17'h00800,
		ST_QI1   = 17'h01000,
		ST_M0    = 17'h02000,
		ST_M1    = 17'h04000,
		ST_FIN   = 17'h08000,
		ST_OUT   = 17'h10000
	} state_t;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

	state_t            state_q, state_d;
	logic [ITER_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              in_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_PI_SI;
		cmd.iter    = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.cap_in = in_fire;
				if (in_fire) state_d = ST_RE0;
			end
			ST_RE0: begin
				cmd.mul_sel = MUL_PI_SI; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				state_d = ST_RE1;
			end
			ST_RE1: begin
				cmd.mul_sel = MUL_PQ_SQ; cmd.acc_en = 1'b1;
				state_d = ST_IM0;
			end
			ST_IM0: begin
				cmd.mul_sel = MUL_PI_SQ; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				cmd.save_re = 1'b1;
				state_d = ST_IM1;
			end
			ST_IM1: begin
				cmd.mul_sel = MUL_PQ_SI; cmd.acc_en = 1'b1; cmd.acc_neg = 1'b1;
				state_d = ST_VINIT;
			end
			ST_VINIT: begin
				cmd.vec_init = 1'b1;
				state_d = ST_VEC;
			end
			ST_VEC: begin
				cmd.vec_step = 1'b1;
				if (cnt_q == LAST_ITER) state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (cnt_q == LAST_ITER) state_d = ST_QR0;
			end
			ST_QR0: begin
				cmd.mul_sel = MUL_K_C; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				cmd.acc_rnd = 1'b1;
				state_d = ST_QR1;
			end
			ST_QR1: begin
				cmd.mul_sel = MUL_G_QR; cmd.acc_en = 1'b1;
				state_d = ST_QI0;
			end
			ST_QI0: begin
				cmd.mul_sel = MUL_K_S; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				cmd.acc_rnd = 1'b1; cmd.qr_load = 1'b1;
				state_d = ST_QI1;
			end
			ST_QI1: begin
				cmd.mul_sel = MUL_G_QI; cmd.acc_en = 1'b1;
				state_d = ST_M0;
			end
			ST_M0: begin
				cmd.mul_sel = MUL_QR_QR; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				cmd.qi_load = 1'b1;
				state_d = ST_M1;
			end
			ST_M1: begin
				cmd.mul_sel = MUL_QI_QI; cmd.acc_en = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.mul_sel = MUL_ERR_GAIN; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
				cmd.acc_rnd = 1'b1; cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_VEC || state_q == ST_ROT) && cnt_q != LAST_ITER)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// An accepted symbol always starts the multiply sequence.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_RE0)
		else $error("accepted symbol did not start the sequence");

	// The result register is only loaded when it is free or being emptied.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// The CORDIC counter is back at zero when a rotation begins.
	a_rot_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEC |=> cnt_q == '0)
		else $error("rotation started with a stale iteration count");

endmodule

`default_nettype wire

// ===== hdl/psd_dp.sv =====
// ----------------------------------------------------------------------------
// psd_dp
// Datapath: shared multiply-accumulate, CORDIC unit, quality and detect state.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_dp #(
	parameter int HISTORY_BITS = psd_pkg::HISTORY_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psd_pkg::psd_cmd_t  cmd,
	input  wire psd_pkg::psd_cfg_t  cfg,
	input  wire logic signed [15:0] sym_i,
	input  wire logic signed [15:0] sym_q,
	output psd_pkg::psd_res_t       res
);
	import psd_pkg::*;

	logic signed [15:0] si_q, sq_q, pi_q, pq_q;
	logic signed [37:0] acc_q, re_q;
	logic signed [35:0] vx_q, vy_q;
	logic [15:0]        ang_q, phase_q;
	logic               zero_q;
	logic [1:0]         bits_q;
	logic signed [19:0] rx_q, ry_q;
	logic signed [17:0] rz_q;
	logic               neg_q;
	logic signed [17:0] qre_q, qim_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic               det_q, valid_q;
	logic [1:0]         dec_q;
	logic [6:0]         metric_q;
	psd_res_t           res_q;

	function automatic logic signed [17:0] sat18(input logic signed [21:0] v);
		if (v > 22'sd131071) return 18'sh1FFFF;
		if (v < -22'sd131072) return 18'sh20000;
		return v[17:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		if (v > 22'sd32767) return 16'sh7FFF;
		if (v < -22'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Shared 18x18 multiplier.
	logic signed [17:0] ma, mb;
	logic signed [35:0] prod;
	logic signed [19:0] c20, s20;
	logic signed [15:0] err;

	assign c20 = neg_q ? -rx_q : rx_q;
	assign s20 = neg_q ? -ry_q : ry_q;
	assign err = phase_q - {bits_q, 14'b0};

	always_comb begin
		case (cmd.mul_sel)
			MUL_PI_SI:    begin ma = 18'(pi_q);     mb = 18'(si_q);   end
			MUL_PQ_SQ:    begin ma = 18'(pq_q);     mb = 18'(sq_q);   end
			MUL_PI_SQ:    begin ma = 18'(pi_q);     mb = 18'(sq_q);   end
			MUL_PQ_SI:    begin ma = 18'(pq_q);     mb = 18'(si_q);   end
			MUL_K_C:      begin ma = 18'sd1311;     mb = c20[17:0];   end
			MUL_K_S:      begin ma = 18'sd1311;     mb = s20[17:0];   end
			MUL_G_QR:     begin ma = 18'sd64225;    mb = qre_q;       end
			MUL_G_QI:     begin ma = 18'sd64225;    mb = qim_q;       end
			MUL_QR_QR:    begin ma = qre_q;         mb = qre_q;       end
			MUL_QI_QI:    begin ma = qim_q;         mb = qim_q;       end
			MUL_ERR_GAIN: begin ma = 18'(err);      mb = {2'b00, cfg.afc_gain}; end
			default:      begin ma = '0;            mb = '0;          end
		endcase
		prod = ma * mb;
	end

	logic signed [37:0] acc_base, acc_term;
	assign acc_base = cmd.acc_clr ? (cmd.acc_rnd ? 38'sd32768 : 38'sd0) : acc_q;
	assign acc_term = cmd.acc_neg ? -38'(prod) : 38'(prod);

	// Vectoring and rotation steps.
	logic signed [35:0] vx0, vy0;
	logic [15:0]        atan_v;
	logic [15:0]        phase_d, rot_a;
	logic [1:0]         bits_d;
	logic signed [17:0] z0;

	assign vx0    = re_q[35:0];
	assign vy0    = acc_q[35:0];
	assign atan_v = psd_atan(cmd.iter);
	assign phase_d = zero_q ? 16'd0 : ang_q;

	always_comb begin
		logic [15:0] tq, tb;
		tq = phase_d + 16'd8192;
		tb = phase_d + 16'd16384;
		bits_d = cfg.qpsk_mode ? tq[15:14] : {tb[15], 1'b0};
		rot_a  = cfg.qpsk_mode ? {phase_d[13:0], 2'b00} : {phase_d[14:0], 1'b0};
		case (rot_a[15:14])
			2'b00, 2'b11: z0 = 18'(signed'(rot_a));
			default:      z0 = 18'(signed'({~rot_a[15], rot_a[14:0]}));
		endcase
	end

	// End-of-symbol decisions.
	logic [36:0]             sqsum;
	logic [43:0]             m100;
	logic [11:0]             m_hi;
	logic [HISTORY_BITS-1:0] hist_d, pre;
	logic                    is_pre, is_zero, det_d;

	always_comb begin
		for (int k = 0; k < HISTORY_BITS; k++) pre[k] = k[0];
		sqsum   = acc_q[36:0];
		m100    = {sqsum, 6'b0} + {1'b0, sqsum, 5'b0} + {5'b0, sqsum, 2'b0};
		m_hi    = m100[43:32];
		hist_d  = {hist_q[HISTORY_BITS-3:0], bits_q};
		is_pre  = (hist_d == pre);
		is_zero = (hist_d == '0);
		if (is_pre)       det_d = 1'b1;
		else if (is_zero) det_d = 1'b0;
		else              det_d = m100 > {5'b0, cfg.squelch_level, 32'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q   <= '0;
			pq_q   <= '0;
			qre_q  <= '0;
			qim_q  <= '0;
			hist_q <= '0;
			det_q  <= 1'b0;
		end else begin
			if (cmd.qr_load) qre_q <= sat18(acc_q[37:16]);
			if (cmd.qi_load) qim_q <= sat18(acc_q[37:16]);
			if (cmd.finish) begin
				hist_q <= hist_d;
				det_q  <= det_d;
				pi_q   <= si_q;
				pq_q   <= sq_q;
				if (is_pre) begin
					qre_q <= 18'sd65536;
					qim_q <= '0;
				end else if (is_zero) begin
					qre_q <= '0;
					qim_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			si_q <= sym_i;
			sq_q <= sym_q;
		end
		if (cmd.acc_en) acc_q <= acc_base + acc_term;
		if (cmd.save_re) re_q <= acc_q;
		if (cmd.vec_init) begin
			zero_q <= (vx0 == '0) && (vy0 == '0);
			if (vx0 < 0) begin
				vx_q  <= -vx0;
				vy_q  <= -vy0;
				ang_q <= 16'd32768;
			end else begin
				vx_q  <= vx0;
				vy_q  <= vy0;
				ang_q <= 16'd0;
			end
		end
		if (cmd.vec_step) begin
			if (vy_q >= 0) begin
				vx_q  <= vx_q + (vy_q >>> cmd.iter);
				vy_q  <= vy_q - (vx_q >>> cmd.iter);
				ang_q <= ang_q + atan_v;
			end else begin
				vx_q  <= vx_q - (vy_q >>> cmd.iter);
				vy_q  <= vy_q + (vx_q >>> cmd.iter);
				ang_q <= ang_q - atan_v;
			end
		end
		if (cmd.decide) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			rx_q    <= 20'sd39797;
			ry_q    <= '0;
			rz_q    <= z0;
			neg_q   <= (rot_a[15:14] == 2'b01) || (rot_a[15:14] == 2'b10);
		end
		if (cmd.rot_step) begin
			if (rz_q >= 0) begin
				rx_q <= rx_q - (ry_q >>> cmd.iter);
				ry_q <= ry_q + (rx_q >>> cmd.iter);
				rz_q <= rz_q - 18'(atan_v);
			end else begin
				rx_q <= rx_q + (ry_q >>> cmd.iter);
				ry_q <= ry_q - (rx_q >>> cmd.iter);
				rz_q <= rz_q + 18'(atan_v);
			end
		end
		if (cmd.finish) begin
			metric_q <= (m_hi > 12'd100) ? 7'd100 : m_hi[6:0];
			valid_q  <= det_d || !cfg.squelch_enable;
			if (cfg.qpsk_mode)
				dec_q <= cfg.reverse_sideband ? 2'(3'd4 - {1'b0, bits_q}) : bits_q;
			else
				dec_q <= (bits_q == 2'd0) ? 2'd1 : 2'd0;
		end
		if (cmd.load_out) begin
			res_q.phase_turn     <= phase_q;
			res_q.decided_bits   <= dec_q;
			res_q.data_valid     <= valid_q;
			res_q.carrier_detect <= det_q;
			res_q.quality_metric <= metric_q;
			res_q.freq_step      <= (valid_q && cfg.afc_enable) ? sat16(acc_q[37:16]) : '0;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== hdl/psk_symbol_detector_dcd_afc.sv =====
// ----------------------------------------------------------------------------
// psk_symbol_detector_dcd_afc
// Differential PSK symbol detector with carrier detect and AFC step output.
// ----------------------------------------------------------------------------
// The two 15-step CORDIC passes and the eleven operations on the single
//   shared multiplier run one after another for each symbol; no new symbol
//   is taken until the previous one has been through all of them.
// A new symbol is taken while the previous result still waits in the output
//   register; a later result waits until that register has been emptied.
// Reset (arst_n low, asynchronous) clears the sequencer, the previous symbol,
//   the quality vector, the dibit history and detect, and restores registers.
`default_nettype none

module psk_symbol_detector_dcd_afc #(
	parameter int HISTORY_BITS = psd_pkg::HISTORY_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [psd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	psd_in_if.sink                           in_ch,
	psd_out_if.source                        out_ch
);
	import psd_pkg::*;

	// Configuration registers. Writes land on the access phase of the bus
	// cycle; an address past the last register is silently ignored.
	psd_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qpsk_mode        <= 1'b0;
			cfg_q.reverse_sideband <= 1'b0;
			cfg_q.squelch_level    <= SQL_LEVEL_RST;
			cfg_q.squelch_enable   <= 1'b1;
			cfg_q.afc_enable       <= 1'b0;
			cfg_q.afc_gain         <= AFC_GAIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_QPSK_MODE:  cfg_q.qpsk_mode        <= pwdata[0];
				REG_REVERSE:    cfg_q.reverse_sideband <= pwdata[0];
				REG_SQL_LEVEL:  cfg_q.squelch_level    <= pwdata[6:0];
				REG_SQL_ENABLE: cfg_q.squelch_enable   <= pwdata[0];
				REG_AFC_ENABLE: cfg_q.afc_enable       <= pwdata[0];
				REG_AFC_GAIN:   cfg_q.afc_gain         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QPSK_MODE:  prdata = {31'b0, cfg_q.qpsk_mode};
			REG_REVERSE:    prdata = {31'b0, cfg_q.reverse_sideband};
			REG_SQL_LEVEL:  prdata = {25'b0, cfg_q.squelch_level};
			REG_SQL_ENABLE: prdata = {31'b0, cfg_q.squelch_enable};
			REG_AFC_ENABLE: prdata = {31'b0, cfg_q.afc_enable};
			REG_AFC_GAIN:   prdata = {16'b0, cfg_q.afc_gain};
			default:        prdata = '0;
		endcase
	end

	// The sequencer owns the handshakes and the result valid flag; the
	// datapath holds every value and follows the sequencer's commands.
	psd_cmd_t cmd;
	psd_res_t res;

	psd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	psd_dp #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.sym_i  (in_ch.sym_i),
		.sym_q  (in_ch.sym_q),
		.res    (res)
	);

	assign out_ch.phase_turn     = res.phase_turn;
	assign out_ch.decided_bits   = res.decided_bits;
	assign out_ch.data_valid     = res.data_valid;
	assign out_ch.carrier_detect = res.carrier_detect;
	assign out_ch.quality_metric = res.quality_metric;
	assign out_ch.freq_step      = res.freq_step;

endmodule

`default_nettype wire

// ===== bench/tb_psk_symbol_detector_dcd_afc.sv =====
// ----------------------------------------------------------------------------
// tb_psk_symbol_detector_dcd_afc
// Self-checking bench for the differential PSK symbol detector. Symbols go in
// through a valid/ready channel and each result is compared with a software
// model of the phase detector, quality average, carrier detect and AFC step.
// The model runs in a small scoreboard class. The bench sweeps the register
// settings in phases, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_psk_symbol_detector_dcd_afc;
	timeunit 1ns;
	timeprecision 1ps;
	import psd_pkg::*;

	localparam int N_REGS = 6;

	// Scoreboard: a bit-exact model of the detector plus the queue of
	// results that it has predicted and the block has not yet delivered.
	class detector_scoreboard;
		psd_cfg_t   cfg;
		logic [15:0] last_i, last_q;
		longint     avg_re, avg_im;
		logic [31:0] history;
		bit         detect;
		psd_res_t   pending[$];
		int         errors;
		int         checked;
		int         detect_count;

		function void clear();
			cfg.qpsk_mode = 1'b0;
			cfg.reverse_sideband = 1'b0;
			cfg.squelch_level = SQL_LEVEL_RST;
			cfg.squelch_enable = 1'b1;
			cfg.afc_enable = 1'b0;
			cfg.afc_gain = AFC_GAIN_RST;
			last_i = '0;
			last_q = '0;
			avg_re = 0;
			avg_im = 0;
			history = '0;
			detect = 1'b0;
		endfunction

		function void set_reg(int idx, logic [31:0] val);
			case (idx)
				REG_QPSK_MODE:  cfg.qpsk_mode = val[0];
				REG_REVERSE:    cfg.reverse_sideband = val[0];
				REG_SQL_LEVEL:  cfg.squelch_level = val[6:0];
				REG_SQL_ENABLE: cfg.squelch_enable = val[0];
				REG_AFC_ENABLE: cfg.afc_enable = val[0];
				REG_AFC_GAIN:   cfg.afc_gain = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] atan_step(int i);
			logic [15:0] t [15] = '{16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651,
				16'd326, 16'd163, 16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1,
				16'd1};
			return t[i];
		endfunction

		// Angle of (x, y) as a fraction of a turn, by vectoring CORDIC.
		function logic [15:0] angle_of(longint x, longint y);
			logic [31:0] ang;
			longint dx, dy;
			ang = 0;
			if (x == 0 && y == 0)
				return 16'd0;
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 32768;
			end
			for (int i = 0; i < 15; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; ang += atan_step(i);
				end else begin
					x -= dx; y += dy; ang -= atan_step(i);
				end
			end
			return ang[15:0];
		endfunction

		// Unit vector at angle a in Q16, by rotating CORDIC.
		function void unit_vector(logic [15:0] a, output longint c, output longint s);
			longint x, y, z, dx, dy;
			bit flip;
			x = 39797;
			y = 0;
			flip = 0;
			if (a < 16384) z = a;
			else if (a >= 49152) z = longint'(a) - 65536;
			else begin
				z = longint'(a) - 32768;
				flip = 1;
			end
			for (int i = 0; i < 15; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_step(i);
				end else begin
					x += dx; y -= dy; z += atan_step(i);
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint clip18(longint v);
			if (v > 131071) return 131071;
			if (v < -131072) return -131072;
			return v;
		endfunction

		// Works out the result of one accepted symbol and queues it.
		function void note_symbol(logic [15:0] si, logic [15:0] sq);
			longint re, im, c, s, m100, err, step;
			logic [15:0] phase, rot, diff;
			logic [1:0] bits, decided;
			psd_res_t r;
			re = longint'($signed(last_i)) * $signed(si)
				+ longint'($signed(last_q)) * $signed(sq);
			im = longint'($signed(last_i)) * $signed(sq)
				- longint'($signed(last_q)) * $signed(si);
			phase = angle_of(re, im);
			if (cfg.qpsk_mode) begin
				rot = phase + 16'd8192;
				bits = rot[15:14];
				unit_vector(phase << 2, c, s);
			end else begin
				rot = phase + 16'd16384;
				bits = {rot[15], 1'b0};
				unit_vector(phase << 1, c, s);
			end
			avg_re = clip18((1311 * c + 64225 * avg_re + 32768) >>> 16);
			avg_im = clip18((1311 * s + 64225 * avg_im + 32768) >>> 16);
			m100 = 100 * (avg_re * avg_re + avg_im * avg_im);
			history = {history[29:0], bits};
			// The alternating preamble forces detect on, a silent history off.
			if (history == 32'hAAAAAAAA) begin
				detect = 1;
				avg_re = 65536;
				avg_im = 0;
			end else if (history == 0) begin
				detect = 0;
				avg_re = 0;
				avg_im = 0;
			end else
				detect = m100 > (longint'(cfg.squelch_level) << 32);
			if (cfg.qpsk_mode)
				decided = cfg.reverse_sideband ? 2'd0 - bits : bits;
			else
				decided = (bits == 0) ? 2'd1 : 2'd0;
			r.phase_turn = phase;
			r.decided_bits = decided;
			r.data_valid = detect || !cfg.squelch_enable;
			r.carrier_detect = detect;
			r.quality_metric = ((m100 >> 32) > 100) ? 7'd100 : 7'(m100 >> 32);
			step = 0;
			if (r.data_valid && cfg.afc_enable) begin
				diff = phase - {bits, 14'd0};
				err = $signed(diff);
				step = (err * longint'(cfg.afc_gain) + 32768) >>> 16;
				if (step > 32767) step = 32767;
				if (step < -32768) step = -32768;
			end
			r.freq_step = 16'(step);
			if (detect) detect_count++;
			last_i = si;
			last_q = sq;
			pending.push_back(r);
		endfunction

		function void check_result(psd_res_t got);
			psd_res_t want;
			checked++;
			if (pending.size() == 0) begin
				$error("result with no symbol outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.phase_turn !== want.phase_turn) begin
				$error("phase_turn: expected %0d, got %0d", want.phase_turn, got.phase_turn);
				errors++;
			end
			if (got.decided_bits !== want.decided_bits) begin
				$error("decided_bits: expected %0d, got %0d", want.decided_bits,
					got.decided_bits);
				errors++;
			end
			if (got.data_valid !== want.data_valid) begin
				$error("data_valid: expected %0d, got %0d", want.data_valid, got.data_valid);
				errors++;
			end
			if (got.carrier_detect !== want.carrier_detect) begin
				$error("carrier_detect: expected %0d, got %0d", want.carrier_detect,
					got.carrier_detect);
				errors++;
			end
			if (got.quality_metric !== want.quality_metric) begin
				$error("quality_metric: expected %0d, got %0d", want.quality_metric,
					got.quality_metric);
				errors++;
			end
			if (got.freq_step !== want.freq_step) begin
				$error("freq_step: expected %0d, got %0d", want.freq_step, got.freq_step);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	psd_in_if  in_ch();
	psd_out_if out_ch();

	psk_symbol_detector_dcd_afc u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	detector_scoreboard sb = new();

	// The receiver side: a long hold-off request from the main process
	// freezes ready for a counted stretch so the pipeline backs up.
	bit hold_request = 0;
	bit calm_ready = 0;
	int stall_left = 0;
	int symbols_sent = 0;

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				psd_res_t got;
				got.phase_turn = out_ch.phase_turn;
				got.decided_bits = out_ch.decided_bits;
				got.data_valid = out_ch.data_valid;
				got.carrier_detect = out_ch.carrier_detect;
				got.quality_metric = out_ch.quality_metric;
				got.freq_step = out_ch.freq_step;
				sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 0;
				stall_left = 600;
			end else if (stall_left == 0 && !calm_ready && $urandom_range(0, 99) < 3)
				stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(40, 120)
					: $urandom_range(1, 5);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	task automatic reg_write(int idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < N_REGS)
			sb.set_reg(idx, val);
	endtask

	bit calm_send = 0;

	// Offers one symbol and waits until it is taken. Valid stays high when
	// no gap follows, so back-to-back items never drop it within a step.
	task automatic send_symbol(logic [15:0] si, logic [15:0] sq);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.sym_i <= si;
		in_ch.sym_q <= sq;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_symbol(si, sq);
		symbols_sent++;
		if (calm_send) gap = 0;
		else begin
			gap = $urandom_range(0, 99);
			gap = gap < 60 ? 0 : gap < 95 ? $urandom_range(1, 4) : $urandom_range(20, 80);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers valid and waits until every predicted result has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	// Constellation point at quarter-turn index k with amplitude a, plus noise.
	int cur_quarter = 0;

	task automatic send_point(int k, int a);
		int ni, nq, pi_, pq;
		int nz;
		nz = a / 16;
		ni = $urandom_range(0, 2 * nz) - nz;
		nq = $urandom_range(0, 2 * nz) - nz;
		case (k & 3)
			0: begin pi_ = a; pq = 0; end
			1: begin pi_ = 0; pq = a; end
			2: begin pi_ = -a; pq = 0; end
			default: begin pi_ = 0; pq = -a; end
		endcase
		send_symbol(16'(pi_ + ni), 16'(pq + nq));
	endtask

	// Random stream: mostly preamble runs, data runs and steady carrier with
	// random content, the rest noise and cut-off runs.
	task automatic random_phase(int count);
		int done, kind, len, a;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(0, 99);
			a = $urandom_range(0, 4) == 0 ? $urandom_range(50, 2000)
				: $urandom_range(2000, 28000);
			calm_send = $urandom_range(0, 5) == 0;
			calm_ready = $urandom_range(0, 5) == 0;
			if (kind < 25) begin
				len = $urandom_range(0, 3) == 0 ? $urandom_range(4, 14) : $urandom_range(16, 22);
				repeat (len) begin
					cur_quarter += 2;
					send_point(cur_quarter, a);
				end
			end else if (kind < 65) begin
				len = $urandom_range(8, 40);
				repeat (len) begin
					cur_quarter += sb.cfg.qpsk_mode ? $urandom_range(0, 3)
						: 2 * $urandom_range(0, 1);
					send_point(cur_quarter, a);
				end
			end else if (kind < 85) begin
				len = $urandom_range(0, 3) == 0 ? $urandom_range(4, 14) : $urandom_range(16, 22);
				repeat (len) send_point(cur_quarter, a);
			end else begin
				len = $urandom_range(1, 5);
				repeat (len) send_symbol(16'($urandom), 16'($urandom));
			end
			done += len;
		end
		calm_send = 0;
		calm_ready = 0;
	endtask

	int phase_count = 0;

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sym_i <= '0;
		in_ch.sym_q <= '0;
		sb.clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, full-scale corners in both signs, a tiny vector, zero.
		send_symbol(16'h0000, 16'h0000);
		send_symbol(16'h7FFF, 16'h0000);
		send_symbol(16'h8000, 16'h8000);
		send_symbol(16'h7FFF, 16'h7FFF);
		send_symbol(16'h8000, 16'h7FFF);
		send_symbol(16'h0001, 16'hFFFF);
		send_symbol(16'h0000, 16'h0000);
		// Sixteen reversals make up the alternating preamble.
		repeat (17) begin
			cur_quarter += 2;
			send_point(cur_quarter, 20000);
		end
		drain();

		// Every register is written here, including index slots past the
		// end of the map, which must be ignored.
		reg_write(REG_QPSK_MODE, 1);
		reg_write(REG_REVERSE, 1);
		reg_write(REG_SQL_LEVEL, 0);
		reg_write(REG_SQL_ENABLE, 1);
		reg_write(REG_AFC_ENABLE, 1);
		reg_write(REG_AFC_GAIN, 65535);
		reg_write(6, 32'hFFFFFFFF);
		reg_write(7, 32'hFFFFFFFF);
		// Steady carrier: an all-zero history drops detect.
		repeat (17) send_point(cur_quarter, 15000);
		for (int k = 0; k < 4; k++) begin
			cur_quarter += k;
			send_point(cur_quarter, 15000);
		end
		phase_count++;

		// Receiver holds off while symbols keep coming.
		hold_request = 1;
		random_phase(160);
		drain();
		phase_count++;

		reg_write(REG_REVERSE, 0);
		reg_write(REG_SQL_LEVEL, 100);
		reg_write(REG_AFC_GAIN, 0);
		random_phase(160);
		drain();
		phase_count++;

		reg_write(REG_QPSK_MODE, 0);
		reg_write(REG_SQL_ENABLE, 0);
		reg_write(REG_AFC_GAIN, 65535);
		random_phase(160);
		drain();
		phase_count++;

		reg_write(REG_SQL_ENABLE, 1);
		reg_write(REG_SQL_LEVEL, $urandom_range(1, 99));
		reg_write(REG_AFC_GAIN, $urandom_range(0, 65535));
		random_phase(160);
		drain();
		phase_count++;

		reg_write(REG_QPSK_MODE, 1);
		reg_write(REG_REVERSE, 1);
		reg_write(REG_SQL_LEVEL, $urandom_range(0, 100));
		reg_write(REG_AFC_ENABLE, $urandom_range(0, 1));
		random_phase(140);
		drain();
		phase_count++;

		$display("%0d symbols over %0d register settings, %0d results checked,",
			symbols_sent, phase_count, sb.checked);
		$display("carrier detect held on %0d of them, %0d mismatches", sb.detect_count,
			sb.errors);
		if (sb.errors == 0)
			$display("psk_symbol_detector_dcd_afc regression: pass");
		else
			$display("psk_symbol_detector_dcd_afc regression: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("psk_symbol_detector_dcd_afc regression: fail");
		$finish;
	end

endmodule
